### rtl/midpoint_lru_page_list_macros.svh
// Assertion macros shared by the midpoint LRU page list design.
`ifndef MIDPOINT_LRU_PAGE_LIST_MACROS_SVH
`define MIDPOINT_LRU_PAGE_LIST_MACROS_SVH

// A condition that must hold on every clock edge out of reset.
`define MLRU_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition in one cycle that implies another in the same cycle.
`define MLRU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition in one cycle that implies another in the following cycle.
`define MLRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mlru_pkg.sv
// Types and constants shared by the midpoint LRU page list modules.
package mlru_pkg;

    // Page number width and payload field widths.
    localparam int PAGE_BITS   = 32;
    localparam int RATIO_W     = 4;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_ADDR_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO_NUM = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO_DEN = 1'b1;

    // Reset values of the ratio registers.
    localparam logic [RATIO_W-1:0] RATIO_NUM_RESET = 4'd5;
    localparam logic [RATIO_W-1:0] RATIO_DEN_RESET = 4'd8;

    // Result outcome codes.
    typedef enum logic [1:0] {
        OUT_MISS_INSERT = 2'd0,
        OUT_HIT_OLD     = 2'd1,
        OUT_HIT_YOUNG   = 2'd2,
        OUT_MISS_FULL   = 2'd3
    } outcome_t;

endpackage

### rtl/mlru_match.sv
// Associative lookup of one page over the occupied list slots.
module mlru_match import mlru_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic [PAGE_BITS-1:0] slots [CAPACITY],
    input  logic [CNT_W-1:0]     count,
    input  logic [PAGE_BITS-1:0] page,
    output logic                 hit,
    output logic [IDX_W-1:0]     pos
);

    logic [CAPACITY-1:0] match;

    // Compare every occupied slot in parallel.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (CNT_W'(i) < count) && (slots[i] == page);
        end
    end

    // The lowest matching position wins.
    always_comb begin
        hit = |match;
        pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match[i]) begin
                pos = IDX_W'(i);
            end
        end
    end

endmodule

### rtl/midpoint_lru_page_list.sv
// Top level of the midpoint-insertion LRU page list.
//
//   Channel   Direction  Beat contents
//   s_        in         page number
//   m_        out        outcome, position, demotion, young and total counts
//   cfg_      in         ratio numerator (index 0), ratio denominator (index 1)
//
// A page beat is registered in the input register at the edge that takes it. The
// lookup, the list shift and the balance test then run in one pass from the input
// register into the result register, which drives m_tvalid and m_tdata. A new
// page is taken every cycle while the result stream is not stalled.
// Reset clears the list counts and valid flags and restores the ratio 5/8.
// The page slots need no clearing: only occupied slots are compared.
// A stalled result holds the input register: one more page is taken, then
// s_tready stays low until the result beat goes out.
`include "midpoint_lru_page_list_macros.svh"

module midpoint_lru_page_list import mlru_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] page
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] outcome, [5:2] found_position, [6] demoted, [38:7] demoted_page,
    // [43:39] young_count, [48:44] total_count, [55:49] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [RATIO_W-1:0]     cfg_wdata
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PROD_W = CNT_W + RATIO_W;

    // Input stage
    logic                 in_valid_reg;
    logic [PAGE_BITS-1:0] in_page_reg;
    // List state
    logic [PAGE_BITS-1:0] slot_reg  [CAPACITY];
    logic [PAGE_BITS-1:0] slot_next [CAPACITY];
    logic [CNT_W-1:0]     entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]     young_reg, young_next;
    logic [RATIO_W-1:0]   ratio_num_reg, ratio_den_reg;
    // Result stage
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                 advance;
    logic                 hit, full, hit_young, do_write, demote;
    logic [IDX_W-1:0]     hit_pos;
    logic [CNT_W-1:0]     ins_c, hi_c, young_hit, old_hit, young_less;
    logic [PROD_W-1:0]    prod_young, prod_old;
    logic [PAGE_BITS-1:0] demoted_page;
    outcome_t             outcome;

    // Handshakes: the processing step moves an item into the result register.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_page_reg <= s_tdata[PAGE_BITS-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_num_reg <= RATIO_NUM_RESET;
            ratio_den_reg <= RATIO_DEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RATIO_NUM: ratio_num_reg <= cfg_wdata;
                REG_RATIO_DEN: ratio_den_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Lookup over the occupied slots.
    mlru_match #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_match (
        .slots (slot_reg),
        .count (entry_count_reg),
        .page  (in_page_reg),
        .hit   (hit),
        .pos   (hit_pos)
    );

    // Insert position and shift range: a hit goes to the front, a miss to
    // the head of the old part unless the list is full.
    always_comb begin
        full      = (entry_count_reg >= CNT_W'(CAPACITY));
        hit_young = hit && (CNT_W'(hit_pos) < young_reg);
        do_write  = hit || !full;
        ins_c     = hit ? '0 : young_reg;
        hi_c      = hit ? CNT_W'(hit_pos) : entry_count_reg;
    end

    // Next slot contents: insert at ins_c, shift the slots above it through hi_c up one place.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        if (g == 0) begin : g_head
            always_comb begin
                slot_next[g] = (do_write && ins_c == '0) ? in_page_reg : slot_reg[g];
            end
        end else begin : g_body
            always_comb begin
                slot_next[g] = slot_reg[g];
                if (do_write) begin
                    if (CNT_W'(g) == ins_c) begin
                        slot_next[g] = in_page_reg;
                    end else if (CNT_W'(g) > ins_c && CNT_W'(g) <= hi_c) begin
                        slot_next[g] = slot_reg[g-1];
                    end
                end
            end
        end
    end

    // Balance test after a hit: demote the young tail when young*den > num*old.
    always_comb begin
        young_hit  = hit_young ? young_reg : young_reg + CNT_W'(1);
        old_hit    = entry_count_reg - young_hit;
        young_less = young_hit - CNT_W'(1);
        prod_young = PROD_W'(young_hit) * PROD_W'(ratio_den_reg);
        prod_old   = PROD_W'(ratio_num_reg) * PROD_W'(old_hit);
        demote     = hit && (young_hit != '0) && (prod_young > prod_old);
        demoted_page = demote ? slot_next[young_less[IDX_W-1:0]] : '0;
    end

    // Next counts and the packed result.
    always_comb begin
        young_next       = !hit ? young_reg : (demote ? young_less : young_hit);
        entry_count_next = (!hit && !full) ? entry_count_reg + CNT_W'(1) : entry_count_reg;
        priority if (hit) begin
            outcome = hit_young ? OUT_HIT_YOUNG : OUT_HIT_OLD;
        end else if (full) begin
            outcome = OUT_MISS_FULL;
        end else begin
            outcome = OUT_MISS_INSERT;
        end
        out_data_next = {
            7'd0,
            COUNT_W'(entry_count_next),
            COUNT_W'(young_next),
            demoted_page,
            demote,
            hit ? POS_W'(hit_pos) : POS_W'(0),
            outcome
        };
    end

    // List state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            young_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else if (advance) begin
            entry_count_reg <= entry_count_next;
            young_reg       <= young_next;
            out_valid_reg   <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg   <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
            for (int i = 0; i < CAPACITY; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    // Checks on the list bookkeeping.
    `MLRU_ASSERT_ALWAYS(a_young_within_list, aclk, aresetn,
        young_reg <= entry_count_reg, "young part exceeds the list")
    `MLRU_ASSERT_ALWAYS(a_count_within_capacity, aclk, aresetn,
        entry_count_reg <= CNT_W'(CAPACITY), "list count exceeds capacity")
    `MLRU_ASSERT_NEXT(a_full_miss_keeps_list, aclk, aresetn,
        advance && !hit && full, $stable(entry_count_reg) && $stable(young_reg),
        "dropped miss changed the list")
    `MLRU_ASSERT_IMPLIES(a_demote_only_on_hit, aclk, aresetn,
        advance && demote, hit && young_hit != '0, "demotion without a hit")

endmodule

### dv/tb_midpoint_lru_page_list.sv
`timescale 1ns / 1ps
// Testbench for the midpoint LRU page list: random page streams checked beat by beat.

// Result fields of one page access, as the block reports them.
typedef struct packed {
    mlru_pkg::outcome_t outcome;
    logic [3:0]         position;
    logic               demoted;
    logic [31:0]        demoted_page;
    logic [4:0]         young_count;
    logic [4:0]         total_count;
} access_result_t;

// Tracks the page list contents and the results that accepted accesses must produce.
class page_list_tracker;
    localparam int DEPTH = 16;

    logic [31:0]    slot_page [DEPTH];
    int             stored;
    int             young_len;
    logic [3:0]     ratio_num;
    logic [3:0]     ratio_den;
    access_result_t awaited_results [$];
    int             mismatches;

    function new();
        stored     = 0;
        young_len  = 0;
        ratio_num  = mlru_pkg::RATIO_NUM_RESET;
        ratio_den  = mlru_pkg::RATIO_DEN_RESET;
        mismatches = 0;
    endfunction

    function void set_ratio(logic [mlru_pkg::CFG_ADDR_W-1:0] idx, logic [3:0] val);
        if (idx == mlru_pkg::REG_RATIO_NUM) begin
            ratio_num = val;
        end else begin
            ratio_den = val;
        end
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    // True once every list slot holds a page.
    function bit is_full();
        return stored >= DEPTH;
    endfunction

    // Apply one access to the list and queue the result it must produce.
    function void note_access(logic [31:0] pg);
        access_result_t r;
        int             hit_at;
        int             old_len;
        r      = '0;
        hit_at = -1;
        for (int i = 0; i < stored; i++) begin
            if (hit_at < 0 && slot_page[i] == pg) hit_at = i;
        end
        if (hit_at >= 0) begin
            // A hit moves the page to the young head, then one balancing step may follow.
            r.position = hit_at[3:0];
            r.outcome  = (hit_at < young_len) ? mlru_pkg::OUT_HIT_YOUNG
                                              : mlru_pkg::OUT_HIT_OLD;
            for (int i = hit_at; i > 0; i--) slot_page[i] = slot_page[i-1];
            slot_page[0] = pg;
            if (r.outcome == mlru_pkg::OUT_HIT_OLD) young_len++;
            old_len = stored - young_len;
            if (young_len > 0 && young_len * ratio_den > ratio_num * old_len) begin
                r.demoted      = 1'b1;
                r.demoted_page = slot_page[young_len-1];
                young_len--;
            end
        end else if (stored >= DEPTH) begin
            // A full list drops the new page and keeps its state.
            r.outcome = mlru_pkg::OUT_MISS_FULL;
        end else begin
            // A new page lands at the head of the old part.
            for (int i = stored; i > young_len; i--) slot_page[i] = slot_page[i-1];
            slot_page[young_len] = pg;
            stored++;
            r.outcome = mlru_pkg::OUT_MISS_INSERT;
        end
        r.young_count = young_len[4:0];
        r.total_count = stored[4:0];
        awaited_results.push_back(r);
    endfunction

    task flag_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Compare one result beat with the oldest outstanding result.
    task check_result(logic [mlru_pkg::OUT_TDATA_W-1:0] beat);
        access_result_t want;
        access_result_t got;
        if (awaited_results.size() == 0) begin
            flag_mismatch($sformatf("result beat %h with no access outstanding", beat));
            return;
        end
        want = awaited_results.pop_front();
        got  = '0;
        got.outcome      = mlru_pkg::outcome_t'(beat[1:0]);
        got.position     = beat[5:2];
        got.demoted      = beat[6];
        got.demoted_page = beat[38:7];
        got.young_count  = beat[43:39];
        got.total_count  = beat[48:44];
        if (got.outcome != want.outcome)
            flag_mismatch($sformatf("outcome %s, expected %s",
                got.outcome.name(), want.outcome.name()));
        if (got.position != want.position)
            flag_mismatch($sformatf("found_position %0d, expected %0d",
                got.position, want.position));
        if (got.demoted != want.demoted)
            flag_mismatch($sformatf("demoted %0b, expected %0b", got.demoted, want.demoted));
        if (got.demoted_page != want.demoted_page)
            flag_mismatch($sformatf("demoted_page %h, expected %h",
                got.demoted_page, want.demoted_page));
        if (got.young_count != want.young_count)
            flag_mismatch($sformatf("young_count %0d, expected %0d",
                got.young_count, want.young_count));
        if (got.total_count != want.total_count)
            flag_mismatch($sformatf("total_count %0d, expected %0d",
                got.total_count, want.total_count));
    endtask
endclass

module tb_midpoint_lru_page_list;
    import mlru_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [31:0] page
    logic                   m_tvalid;
    logic                   m_tready;
    // [1:0] outcome, [5:2] found_position, [6] demoted, [38:7] demoted_page,
    // [43:39] young_count, [48:44] total_count, [55:49] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [RATIO_W-1:0]     cfg_wdata;

    page_list_tracker tracker;
    logic [31:0]      seen_pages [$];
    bit               sender_burst;

    midpoint_lru_page_list DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with a 12 ns period.
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Accepted beats on both channels feed the tracker.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) tracker.note_access(s_tdata);
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
    end

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Choose the next page: mostly stored pages, plus new pages, near misses and old pages.
    function automatic logic [31:0] choose_page(int fresh_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < fresh_pct || tracker.stored == 0) return $urandom;
        r = $urandom_range(0, 99);
        if (r < 10)
            return tracker.slot_page[$urandom_range(0, tracker.stored - 1)]
                   ^ (32'h1 << $urandom_range(0, 31));
        if (r < 20 && seen_pages.size() > 0)
            return seen_pages[$urandom_range(0, seen_pages.size() - 1)];
        return tracker.slot_page[$urandom_range(0, tracker.stored - 1)];
    endfunction

    // Offer one page beat and hold it until taken, then idle for a while.
    task automatic send_page(logic [31:0] pg);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = pg;
        do @(posedge aclk); while (!s_tready);
        seen_pages.push_back(pg);
        if (seen_pages.size() > 64) void'(seen_pages.pop_front());
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = $urandom;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_ratio(logic [CFG_ADDR_W-1:0] idx, logic [RATIO_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        tracker.set_ratio(idx, val);
    endtask

    task automatic set_ratios(logic [RATIO_W-1:0] num, logic [RATIO_W-1:0] den);
        drain();
        write_ratio(REG_RATIO_NUM, num);
        write_ratio(REG_RATIO_DEN, den);
    endtask

    task automatic run_phase(logic [RATIO_W-1:0] num, logic [RATIO_W-1:0] den,
                             int items, int fresh_pct);
        set_ratios(num, den);
        sender_burst = ($urandom_range(0, 3) == 0);
        repeat (items) send_page(choose_page(fresh_pct));
    endtask

    // Result-side backpressure: ready runs of varied length broken by stalls.
    initial begin
        int hold;
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            hold = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
            @(negedge aclk);
            m_tready = 1'b1;
            repeat (hold) @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    // Main sequence.
    initial begin
        tracker      = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = REG_RATIO_NUM;
        cfg_wdata    = '0;
        sender_burst = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extreme pages, insertion at the old head, hits on both sides.
        send_page(32'h0000_0000);
        send_page(32'hFFFF_FFFF);
        send_page(32'h0000_0000);
        send_page(32'h1234_5678);
        send_page(32'hA5A5_A5A5);
        send_page(32'h5A5A_5A5A);
        send_page(32'h8000_0000);
        send_page(32'h0000_0001);
        send_page(32'h7FFF_FFFF);
        send_page(32'hFFFF_FFFE);
        send_page(32'h0000_0001);
        send_page(32'h1234_5678);
        send_page(32'hFFFF_FFFF);
        send_page(32'h0000_0001);
        send_page(32'h8000_0000);

        // Zero denominator never demotes, so the young part keeps growing.
        set_ratios(4'd5, 4'd0);
        send_page(32'h5A5A_5A5A);
        send_page(32'hA5A5_A5A5);
        send_page(32'h7FFF_FFFF);
        send_page(32'hFFFF_FFFE);
        send_page(32'h0000_0000);

        // Zero numerator demotes after every hit.
        set_ratios(4'd0, 4'd15);
        send_page(32'h0000_0000);
        send_page(32'h1234_5678);
        send_page(32'hFFFF_FFFF);
        send_page(32'h8000_0000);
        send_page(32'h0000_0001);

        // Random: fill the list under the reset ratio, then one page past full.
        run_phase(RATIO_NUM_RESET, RATIO_DEN_RESET, 100, 25);
        while (!tracker.is_full()) send_page($urandom);
        send_page($urandom);

        // Random: full list under a spread of ratios, extremes included.
        run_phase(4'd1,  4'd15, 45, 15);
        run_phase(4'd15, 4'd1,  45, 15);
        run_phase(4'd15, 4'd15, 45, 15);
        run_phase(4'd1,  4'd1,  45, 15);
        run_phase(4'd0,  4'd1,  40, 15);
        run_phase(4'd1,  4'd0,  40, 15);
        run_phase(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)), 45, 15);
        run_phase(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)), 45, 15);

        // Let the last results arrive, then watch for stray beats.
        drain();
        repeat (10) @(posedge aclk);
        if (tracker.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
